>>> rtl/iap_pkg.sv
`default_nettype none
// Shared constants for the in-application flash controller.
// No dependencies; used by iap_flash_controller_unit and iap_urem.
package iap_pkg;

  // Bus access kind
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Register selects
  localparam logic [2:0] REG_DATA    = 3'd0;
  localparam logic [2:0] REG_ADDR_HI = 3'd1;
  localparam logic [2:0] REG_ADDR_LO = 3'd2;
  localparam logic [2:0] REG_COMMAND = 3'd3;
  localparam logic [2:0] REG_TRIGGER = 3'd4;

  // Command codes
  localparam logic [1:0] CMD_IDLE    = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_PROGRAM = 2'd2;
  localparam logic [1:0] CMD_ERASE   = 2'd3;

  // Trigger sequence and erased value
  localparam logic [7:0] ARM_CODE  = 8'h5A;
  localparam logic [7:0] FIRE_CODE = 8'hA5;
  localparam logic [7:0] ERASED    = 8'hFF;

  // Address register width
  localparam int ADDR_W = 16;

endpackage
`default_nettype wire

>>> rtl/iap_flash_controller_unit.sv
`default_nettype none
// Top level of the in-application flash controller: register port, trigger
// sequencer and flash store. Depends on iap_pkg, iap_ram and iap_urem.
//
// Usage: a bus access (func, reg_select, wdata) is taken at a clock edge with
// start high and busy low. Its result, rdata, appears for one cycle with done
// high; the receiver cannot hold it off.
// Register reads and writes, and trigger writes that do not fire a command,
// answer in the next cycle and may be issued every cycle.
// A fired command holds busy while it runs: the address is wrapped by a
// three-stage reciprocal remainder unit, then a load or program passes
// through a read-issue and a read-use state; done rises as busy falls.
// A sector erase runs a second three-stage remainder for the
// sector offset, then writes one byte per cycle through the store's single
// write port over the whole sector, or up to the end of the store where the
// sector is clipped; done rises as busy falls.
// After reset the store is filled with 0xFF one byte a cycle, and busy stays
// high until it is full; only the enable register can be written meanwhile.
// The enable register may be written at any edge through iap_enable_we.
module iap_flash_controller_unit #(
  parameter int FLASH_DEPTH  = 1024,
  parameter int SECTOR_BYTES = 512
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        iap_enable_we,
  input  wire        iap_enable_wdata,
  input  wire        start,
  output logic       busy,
  input  wire        func,
  input  wire  [2:0] reg_select,
  input  wire  [7:0] wdata,
  output logic       done,
  output logic [7:0] rdata
);

  localparam int AW = $clog2(FLASH_DEPTH);
  localparam int PW = $clog2(FLASH_DEPTH + 1);
  localparam int EW = iap_pkg::ADDR_W + 1;
  localparam logic [EW-1:0] DEPTH_E  = EW'(FLASH_DEPTH);
  localparam logic [EW-1:0] SECTOR_E = EW'(SECTOR_BYTES);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_WRAP, S_SECT, S_RD_ISSUE, S_RD_USE, S_ERASE
  } state_t;

  state_t state;

  logic                        iap_enable;
  logic [7:0]                  data_byte;
  logic [iap_pkg::ADDR_W-1:0]  flash_address;
  logic [1:0]                  command_code;
  logic                        trigger_armed;
  logic [AW-1:0]               addr_w;
  logic [PW-1:0]               ptr;
  logic [PW-1:0]               lim;

  logic                        accept;
  logic                        fire;
  logic                        wrap_done;
  logic [iap_pkg::ADDR_W-1:0]  wrap_rem;
  logic                        sect_start;
  logic                        sect_done;
  logic [iap_pkg::ADDR_W-1:0]  sect_rem;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [7:0]                  ram_wdata;
  logic [7:0]                  ram_q;

  logic [7:0]                  read_value;
  logic [AW-1:0]               sect_base;
  logic [EW-1:0]               sect_end;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign fire   = accept && (func == iap_pkg::FUNC_WRITE) &&
                  (reg_select == iap_pkg::REG_TRIGGER) && iap_enable &&
                  (wdata == iap_pkg::FIRE_CODE) && trigger_armed &&
                  (command_code != iap_pkg::CMD_IDLE);

  // Enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      iap_enable <= 1'b0;
    end else if (iap_enable_we) begin
      iap_enable <= iap_enable_wdata;
    end
  end

  // Register read mux
  always_comb begin
    unique case (reg_select)
      iap_pkg::REG_DATA:    read_value = data_byte;
      iap_pkg::REG_ADDR_HI: read_value = flash_address[15:8];
      iap_pkg::REG_ADDR_LO: read_value = flash_address[7:0];
      iap_pkg::REG_COMMAND: read_value = {6'd0, command_code};
      default:              read_value = 8'd0;
    endcase
  end

  // Sector offset is taken from the wrapped address once it is known
  assign sect_start = (state == S_WRAP) && wrap_done &&
                      (command_code == iap_pkg::CMD_ERASE);

  // Sector bounds, before clipping at the end of the store
  assign sect_base = addr_w - sect_rem[AW-1:0];
  assign sect_end  = EW'(sect_base) + SECTOR_E;

  // Store write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr[AW-1:0];
    ram_wdata = iap_pkg::ERASED;
    unique case (state)
      S_CLEAR, S_ERASE: ram_we = 1'b1;
      S_RD_USE: begin
        ram_we    = (command_code == iap_pkg::CMD_PROGRAM);
        ram_waddr = addr_w;
        ram_wdata = ram_q & data_byte;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // Sequencer, register file and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      done          <= 1'b0;
      data_byte     <= 8'd0;
      flash_address <= '0;
      command_code  <= iap_pkg::CMD_IDLE;
      trigger_armed <= 1'b0;
      ptr           <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          ptr <= ptr + 1'b1;
          if (ptr == PW'(FLASH_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            rdata <= (func == iap_pkg::FUNC_READ) ? read_value : 8'd0;
            done  <= !fire;
            if (fire) begin
              state <= S_WRAP;
            end
            if (func == iap_pkg::FUNC_WRITE) begin
              unique case (reg_select)
                iap_pkg::REG_DATA:    data_byte <= wdata;
                iap_pkg::REG_ADDR_HI: flash_address[15:8] <= wdata;
                iap_pkg::REG_ADDR_LO: flash_address[7:0] <= wdata;
                iap_pkg::REG_COMMAND: command_code <= wdata[1:0];
                iap_pkg::REG_TRIGGER: begin
                  trigger_armed <= iap_enable && (wdata == iap_pkg::ARM_CODE);
                end
                default: ;
              endcase
            end
          end
        end
        S_WRAP: begin
          if (wrap_done) begin
            addr_w <= wrap_rem[AW-1:0];
            state  <= (command_code == iap_pkg::CMD_ERASE) ? S_SECT : S_RD_ISSUE;
          end
        end
        S_SECT: begin
          if (sect_done) begin
            ptr   <= PW'(sect_base);
            lim   <= (sect_end > DEPTH_E) ? PW'(FLASH_DEPTH) : PW'(sect_end);
            state <= S_ERASE;
          end
        end
        S_RD_ISSUE: state <= S_RD_USE;
        S_RD_USE: begin
          if (command_code == iap_pkg::CMD_LOAD) begin
            data_byte <= ram_q;
          end
          rdata <= 8'd0;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_ERASE: begin
          ptr <= ptr + 1'b1;
          if (ptr + 1'b1 == lim) begin
            rdata <= 8'd0;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Address wrap to the store depth
  iap_urem #(
    .DIVISOR (FLASH_DEPTH)
  ) u_wrap (
    .clk      (clk),
    .rst      (rst),
    .start    (fire),
    .dividend (flash_address),
    .done     (wrap_done),
    .rem      (wrap_rem)
  );

  // Offset of the wrapped address within its sector
  iap_urem #(
    .DIVISOR (SECTOR_BYTES)
  ) u_sect (
    .clk      (clk),
    .rst      (rst),
    .start    (sect_start),
    .dividend (wrap_rem),
    .done     (sect_done),
    .rem      (sect_rem)
  );

  iap_ram #(
    .WIDTH (8),
    .DEPTH (FLASH_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_w),
    .rdata (ram_q)
  );

  // A result only ever leaves with the sequencer back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("result strobed while sequencer busy");

  // A plain register read always answers in the next cycle
  a_read_next: assert property (@(posedge clk) disable iff (rst)
    (accept && func == iap_pkg::FUNC_READ) |=> done)
    else $error("register read not answered");

  // Non-zero read data only follows an accepted read request
  a_rdata_src: assert property (@(posedge clk) disable iff (rst)
    (done && rdata != 8'd0) |-> $past(accept && func == iap_pkg::FUNC_READ))
    else $error("non-zero result without a read request");

  // The store is never written while the port is open for requests
  a_we_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> busy) else $error("store write while idle");

  // Each remainder unit only finishes while the sequencer waits on it
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (wrap_done |-> state == S_WRAP) and (sect_done |-> state == S_SECT))
    else $error("unexpected remainder completion");

endmodule
`default_nettype wire

>>> rtl/iap_ram.sv
`default_nettype none
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module iap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/iap_urem.sv
`default_nettype none
// Remainder of a 16-bit dividend by a fixed divisor through reciprocal
// multiplication, three pipeline stages. Depends on iap_pkg.
module iap_urem #(
  parameter int DIVISOR = 512
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  input  wire  [iap_pkg::ADDR_W-1:0] dividend,
  output logic                       done,
  output logic [iap_pkg::ADDR_W-1:0] rem
);

  localparam int AW    = iap_pkg::ADDR_W;
  localparam int MW    = AW + 1;
  localparam int PRODW = AW + MW;
  // Rounded-up reciprocal, exact for every dividend below 2**AW
  localparam int SHIFT = AW + $clog2(DIVISOR);
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0] RECIP_C   = MW'(RECIP);
  localparam logic [MW-1:0] DIVISOR_C = MW'(DIVISOR);

  logic             v1;
  logic             v2;
  logic [PRODW-1:0] prod;
  logic [AW-1:0]    x1;
  logic [AW-1:0]    x2;
  logic [AW-1:0]    quot;
  logic [AW-1:0]    qd;

  assign quot = AW'(prod >> SHIFT);

  // Stage 1: scaled product, stage 2: quotient times divisor, stage 3: subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
    prod <= PRODW'(dividend) * PRODW'(RECIP_C);
    x1   <= dividend;
    qd   <= AW'(PRODW'(quot) * PRODW'(DIVISOR_C));
    x2   <= x1;
    rem  <= x2 - qd;
  end

endmodule
`default_nettype wire
